### rtl/aovc_pkg.sv
// Shared constants, status codes and control structs for the ADC oversampling
// averager with reference correction. No dependencies; every other file uses it.
package aovc_pkg;

  // Sample width and derived datapath widths.
  localparam int SAMPLE_BITS = 12;
  localparam int CNT_W       = 16;
  localparam int ACC_W       = SAMPLE_BITS + CNT_W;
  localparam int CAL_W       = 12;
  localparam int MV_W        = 13;
  localparam int VAL_W       = 16;
  localparam int STAT_W      = 2;
  localparam int MUL_A_W     = (SAMPLE_BITS > MV_W) ? SAMPLE_BITS : MV_W;
  localparam int NUM_W       = MUL_A_W + CAL_W;
  localparam int DIV_W       = (ACC_W > NUM_W) ? ACC_W : NUM_W;
  // The divisor is either the pair count (up to 65536) or a reference average.
  localparam int DVS_W       = CNT_W + 1;
  localparam int DIV_CNT_W   = $clog2(DIV_W);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_CAL      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_MV       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE         = 2'd3;

  localparam logic [CNT_W-1:0] RST_SAMPLE_COUNT = 16'd1;
  localparam logic [CAL_W-1:0] RST_REF_CAL      = 12'd1638;
  localparam logic [MV_W-1:0]  RST_CAL_MV       = 13'd3300;

  // Result status codes.
  localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_CONV_ERR = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_REF_ZERO = 2'd2;

  // Divider operand selection.
  typedef logic [1:0] div_sel_t;
  localparam div_sel_t DSEL_REF = 2'd0;
  localparam div_sel_t DSEL_TGT = 2'd1;
  localparam div_sel_t DSEL_FIN = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              acc_take;
    logic              run_clear;
    logic              div_start;
    div_sel_t          div_sel;
    logic              avg_r_load;
    logic              avg_t_load;
    logic              num_load;
    logic              res_load;
    logic [STAT_W-1:0] res_status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic run_done;
    logic div_done;
    logic avg_r_zero;
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/aovc_if.sv
// Valid/ready channel interfaces for sample pairs, results and register writes.
// Depends on aovc_pkg for field widths.
interface aovc_in_if;
  logic                             valid;
  logic                             ready;
  logic [aovc_pkg::SAMPLE_BITS-1:0] target_sample;
  logic [aovc_pkg::SAMPLE_BITS-1:0] reference_sample;
  logic                             sample_error;

  modport source (output valid, target_sample, reference_sample, sample_error, input ready);
  modport sink   (input valid, target_sample, reference_sample, sample_error, output ready);
endinterface

interface aovc_out_if;
  logic                        valid;
  logic                        ready;
  logic [aovc_pkg::VAL_W-1:0]  result_value;
  logic [aovc_pkg::STAT_W-1:0] result_status;

  modport source (output valid, result_value, result_status, input ready);
  modport sink   (input valid, result_value, result_status, output ready);
endinterface

interface aovc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [aovc_pkg::CFG_IDX_W-1:0]  index;
  logic [aovc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/aovc_div.sv
// Shared restoring divider, one quotient bit per cycle until all DIV_W bits are formed.
// Depends on aovc_pkg for operand widths.
module aovc_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [aovc_pkg::DIV_W-1:0]   dividend,
  input  logic [aovc_pkg::DVS_W-1:0]   divisor,
  output logic [aovc_pkg::DIV_W-1:0]   quotient,
  output logic                         done
);

  logic [aovc_pkg::DIV_W-1:0]     quo;
  logic [aovc_pkg::DVS_W-1:0]     rem;
  logic [aovc_pkg::DVS_W-1:0]     dvs;
  logic                           busy;
  logic [aovc_pkg::DIV_CNT_W-1:0] cnt;
  logic [aovc_pkg::DVS_W:0]       rem_shift;
  logic [aovc_pkg::DVS_W:0]       rem_diff;
  logic                           ge;
  logic [aovc_pkg::DVS_W-1:0]     rem_new;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    rem_shift = {rem, quo[aovc_pkg::DIV_W-1]};
    rem_diff  = rem_shift - {1'b0, dvs};
    ge        = (rem_shift >= {1'b0, dvs});
    rem_new   = ge ? rem_diff[aovc_pkg::DVS_W-1:0] : rem_shift[aovc_pkg::DVS_W-1:0];
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == aovc_pkg::DIV_CNT_W'(aovc_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder registers; the quotient fills in from the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[aovc_pkg::DIV_W-2:0], ge};
      rem <= rem_new;
    end
  end

  assign quotient = quo;

endmodule

### rtl/aovc_dp.sv
// Datapath: configuration registers, accumulators, pair count, averages,
// multiplier, shared divider and result register. Depends on aovc_pkg, aovc_if, aovc_div.
module aovc_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  aovc_pkg::dp_cmd_t                cmd,
  output aovc_pkg::dp_stat_t               stat,
  input  logic [aovc_pkg::SAMPLE_BITS-1:0] target_sample,
  input  logic [aovc_pkg::SAMPLE_BITS-1:0] reference_sample,
  aovc_cfg_if.sink                         cfg,
  aovc_out_if.source                       results
);

  logic [aovc_pkg::CNT_W-1:0]       sample_count;
  logic [aovc_pkg::CAL_W-1:0]       ref_cal;
  logic [aovc_pkg::MV_W-1:0]        cal_mv;
  logic                             mode;

  logic [aovc_pkg::ACC_W-1:0]       acc_t;
  logic [aovc_pkg::ACC_W-1:0]       acc_r;
  logic [aovc_pkg::CNT_W-1:0]       pairs;
  logic [aovc_pkg::CNT_W-1:0]       pairs_next;
  logic [aovc_pkg::CNT_W-1:0]       goal;
  logic                             run_done;

  logic [aovc_pkg::SAMPLE_BITS-1:0] avg_r;
  logic [aovc_pkg::SAMPLE_BITS-1:0] avg_t;
  logic [aovc_pkg::MUL_A_W-1:0]     mul_a;
  logic [aovc_pkg::NUM_W-1:0]       num;

  logic [aovc_pkg::DIV_W-1:0]       div_dividend;
  logic [aovc_pkg::DVS_W-1:0]       div_divisor;
  logic [aovc_pkg::DIV_W-1:0]       div_quotient;
  logic                             div_done;

  logic                             out_valid;
  logic                             out_valid_next;
  logic [aovc_pkg::VAL_W-1:0]       out_value;
  logic [aovc_pkg::STAT_W-1:0]      out_status;

  // Register writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= aovc_pkg::RST_SAMPLE_COUNT;
      ref_cal      <= aovc_pkg::RST_REF_CAL;
      cal_mv       <= aovc_pkg::RST_CAL_MV;
      mode         <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        aovc_pkg::REG_SAMPLE_COUNT: sample_count <= cfg.data[aovc_pkg::CNT_W-1:0];
        aovc_pkg::REG_REF_CAL:      ref_cal      <= cfg.data[aovc_pkg::CAL_W-1:0];
        aovc_pkg::REG_CAL_MV:       cal_mv       <= cfg.data[aovc_pkg::MV_W-1:0];
        aovc_pkg::REG_MODE:         mode         <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // End of run: the incremented count wrapped, or reached the target (zero counts as one).
  always_comb begin
    pairs_next = pairs + 1'b1;
    goal       = (sample_count == '0) ? aovc_pkg::CNT_W'(1) : sample_count;
    run_done   = (pairs_next == '0) || (pairs_next >= goal);
  end

  assign stat.run_done = run_done;

  // Accumulators and pair count.
  always_ff @(posedge clk) begin
    if (rst || cmd.run_clear) begin
      acc_t <= '0;
      acc_r <= '0;
      pairs <= '0;
    end else if (cmd.acc_take) begin
      acc_t <= acc_t + aovc_pkg::ACC_W'(target_sample);
      acc_r <= acc_r + aovc_pkg::ACC_W'(reference_sample);
      pairs <= pairs_next;
    end
  end

  // Divider operand selection; a wrapped count divides by 65536.
  always_comb begin
    case (cmd.div_sel)
      aovc_pkg::DSEL_REF: begin
        div_dividend = aovc_pkg::DIV_W'(acc_r);
        div_divisor  = {pairs == '0, pairs};
      end
      aovc_pkg::DSEL_TGT: begin
        div_dividend = aovc_pkg::DIV_W'(acc_t);
        div_divisor  = {pairs == '0, pairs};
      end
      aovc_pkg::DSEL_FIN: begin
        div_dividend = aovc_pkg::DIV_W'(num);
        div_divisor  = aovc_pkg::DVS_W'(avg_r);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  aovc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  assign stat.div_done   = div_done;
  assign stat.avg_r_zero = (div_quotient == '0);

  // Averages and the numerator product.
  assign mul_a = mode ? aovc_pkg::MUL_A_W'(cal_mv) : aovc_pkg::MUL_A_W'(avg_t);

  always_ff @(posedge clk) begin
    if (cmd.avg_r_load) begin
      avg_r <= div_quotient[aovc_pkg::SAMPLE_BITS-1:0];
    end
    if (cmd.avg_t_load) begin
      avg_t <= div_quotient[aovc_pkg::SAMPLE_BITS-1:0];
    end
    if (cmd.num_load) begin
      num <= aovc_pkg::NUM_W'(mul_a) * aovc_pkg::NUM_W'(ref_cal);
    end
  end

  // Result register: frees on a transfer, loads when the controller finishes an item.
  assign stat.out_free = !out_valid || results.ready;

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.res_load) begin
      out_valid_next = 1'b1;
    end else if (results.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_status <= cmd.res_status;
      out_value  <= (cmd.res_status == aovc_pkg::STATUS_OK) ?
                    div_quotient[aovc_pkg::VAL_W-1:0] : '0;
    end
  end

  assign results.valid         = out_valid;
  assign results.result_value  = out_value;
  assign results.result_status = out_status;

endmodule

### rtl/aovc_ctrl.sv
// Controller state machine: takes sample pairs, then sequences the three
// divisions and the multiply of a finished run. Depends on aovc_pkg.
module aovc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_error,
  output logic               in_ready,
  output aovc_pkg::dp_cmd_t  cmd,
  input  aovc_pkg::dp_stat_t stat
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_REF_GO   = 3'd1;
  localparam logic [2:0] S_REF_WAIT = 3'd2;
  localparam logic [2:0] S_TGT_WAIT = 3'd3;
  localparam logic [2:0] S_MUL      = 3'd4;
  localparam logic [2:0] S_FIN_GO   = 3'd5;
  localparam logic [2:0] S_FIN_WAIT = 3'd6;
  localparam logic [2:0] S_EMIT     = 3'd7;

  logic [2:0]                  state;
  logic [2:0]                  state_next;
  logic [aovc_pkg::STAT_W-1:0] emit_status;
  logic [aovc_pkg::STAT_W-1:0] emit_status_next;

  // Next state and datapath commands.
  always_comb begin
    state_next       = state;
    emit_status_next = emit_status;
    in_ready         = 1'b0;
    cmd              = '0;
    cmd.div_sel      = aovc_pkg::DSEL_REF;
    cmd.res_status   = emit_status;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_error) begin
            cmd.run_clear    = 1'b1;
            emit_status_next = aovc_pkg::STATUS_CONV_ERR;
            state_next       = S_EMIT;
          end else begin
            cmd.acc_take = 1'b1;
            if (stat.run_done) begin
              state_next = S_REF_GO;
            end
          end
        end
      end
      S_REF_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = aovc_pkg::DSEL_REF;
        state_next    = S_REF_WAIT;
      end
      S_REF_WAIT: begin
        if (stat.div_done) begin
          cmd.avg_r_load = 1'b1;
          if (stat.avg_r_zero) begin
            cmd.run_clear    = 1'b1;
            emit_status_next = aovc_pkg::STATUS_REF_ZERO;
            state_next       = S_EMIT;
          end else begin
            // Target sum is captured by the divider on this edge, so the run can clear.
            cmd.div_start = 1'b1;
            cmd.div_sel   = aovc_pkg::DSEL_TGT;
            cmd.run_clear = 1'b1;
            state_next    = S_TGT_WAIT;
          end
        end
      end
      S_TGT_WAIT: begin
        if (stat.div_done) begin
          cmd.avg_t_load = 1'b1;
          state_next     = S_MUL;
        end
      end
      S_MUL: begin
        cmd.num_load = 1'b1;
        state_next   = S_FIN_GO;
      end
      S_FIN_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = aovc_pkg::DSEL_FIN;
        state_next    = S_FIN_WAIT;
      end
      S_FIN_WAIT: begin
        if (stat.div_done) begin
          emit_status_next = aovc_pkg::STATUS_OK;
          state_next       = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      emit_status <= aovc_pkg::STATUS_OK;
    end else begin
      state       <= state_next;
      emit_status <= emit_status_next;
    end
  end

endmodule

### rtl/adc_oversample_vref_correct.sv
// A pair that does not end a run is added to the sums. A failed pair gives an error result
// through the emit state and the result register. A pair that ends a run gives its result
// after three passes through the shared one-bit-per-cycle divider, or one pass if the
// reference average is zero. Throughput: one pair per cycle inside a run; after the last
// pair no new pair is taken until its result is loaded. Reset (synchronous, rst high)
// restores the register defaults, clears the run and the result register.
module adc_oversample_vref_correct (
  input  logic        clk,
  input  logic        rst,
  aovc_in_if.sink     samples,
  aovc_out_if.source  results,
  aovc_cfg_if.sink    cfg
);

  aovc_pkg::dp_cmd_t  cmd;
  aovc_pkg::dp_stat_t stat;

  // Sequencing of accumulation and the end-of-run arithmetic.
  aovc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_error (samples.sample_error),
    .in_ready (samples.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Registers, sums, divider and the result stage.
  aovc_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .target_sample    (samples.target_sample),
    .reference_sample (samples.reference_sample),
    .cfg              (cfg),
    .results          (results)
  );

endmodule

### rtl/aovc_check.sv
// Port-level checks for adc_oversample_vref_correct, attached by bind.
// Depends on aovc_pkg for widths and status codes.
module aovc_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_error,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [aovc_pkg::VAL_W-1:0]  out_value,
  input logic [aovc_pkg::STAT_W-1:0] out_status
);

  // A result that waits is held unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("result changed or dropped while stalled");

  // Failed results always carry a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != aovc_pkg::STATUS_OK |-> out_value == '0)
    else $error("non-ok result with nonzero value");

  // Reset empties the result register.
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A failed pair makes the block stop taking pairs until its result is queued.
  a_err_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_error |=> !in_ready)
    else $error("pair taken right after a failed pair");

endmodule

bind adc_oversample_vref_correct aovc_check u_check (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (samples.valid),
  .in_ready   (samples.ready),
  .in_error   (samples.sample_error),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_value  (results.result_value),
  .out_status (results.result_status)
);
